>>> rtl/core/ubei_pkg.sv
// Package for the unaligned byte extract/insert block.
// Holds the input and result payload structs, item kind codes and mode fields.
// No dependencies.
`default_nettype none

package ubei_pkg;

  // Window size default and fixed value width
  localparam int WINDOW_BYTES_DEF = 64;
  localparam int VALUE_BYTES      = 32;
  localparam int VALUE_WORDS      = 4;

  // Item kinds
  localparam logic [1:0] KIND_LOAD_WIN = 2'd0;
  localparam logic [1:0] KIND_LOAD_VAL = 2'd1;
  localparam logic [1:0] KIND_EXEC     = 2'd2;

  // Mode word fields and limit
  localparam logic [19:0] MODE_LEFT   = 20'h02000;
  localparam logic [19:0] MODE_LITTLE = 20'h04000;
  localparam logic [19:0] MODE_LIMIT  = 20'h7FFFF;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  word_index;
    logic [63:0] data_word;
    logic [19:0] op_mode;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [63:0] out_word;
    logic [2:0]  out_index;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/unaligned_byte_extract_insert.sv
// Top level of the unaligned byte extract/insert block.
// Depends on ubei_pkg for payload structs, kind codes and mode constants.
//
// Usage:
//   in_*  : valid/ready channel of in_t items. Kind 0 loads a 64-bit window
//           word, kind 1 a value word (word 0 most significant), kind 2
//           executes an extract (is_write 0) or insert (is_write 1).
//   out_* : valid/ready channel of out_t results.
// Loads give no result. An execute is sequenced word by word: a shared
// eight-byte lane unit builds one 64-bit word per cycle while the
// receiver does not stall, so a read gives four words, a write
// min(WINDOW_BYTES/8, 8) words, and an out-of-range mode one error word.
// The execute transfer puts the sequencer in its run state, from which
// the first result is registered in the output register; the input is
// not ready while results are being produced. The final word may
// still wait in the output register while the next item is accepted.
// A receiver stall holds the sequencer on the current word.
// Reset clears the sequencer and output valid; window and value stores
// are undefined until loaded.
`default_nettype none

module unaligned_byte_extract_insert #(
  parameter int WINDOW_BYTES = ubei_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ubei_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ubei_pkg::out_t     out_data
);

  localparam int WW   = WINDOW_BYTES / 8;
  localparam int NOUT = (WW > 8) ? 8 : WW;
  localparam int BW   = $clog2(WINDOW_BYTES);
  localparam int AW   = $clog2(WINDOW_BYTES + ubei_pkg::VALUE_BYTES) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Stores, byte 0 is the top byte of word 0
  logic [WINDOW_BYTES-1:0][7:0]          win_r;
  logic [ubei_pkg::VALUE_BYTES-1:0][7:0] val_r;

  logic           state_r, state_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [AW-1:0]  offs_r, len_r, base_r;
  logic           little_r, wr_r, err_r;
  logic           out_valid_r, out_valid_nxt;
  ubei_pkg::out_t out_r, out_nxt;

  // Decode of the incoming mode
  logic [6:0]    dec_off;
  logic [5:0]    dec_lenf;
  logic          dec_err;
  logic [AW-1:0] dec_offv, dec_lenv, dec_len, dec_base;

  always_comb begin
    dec_off  = in_data.op_mode[6:0];
    dec_lenf = in_data.op_mode[12:7];
    dec_err  = (32'(dec_off) > WINDOW_BYTES) || (32'(dec_lenf) > ubei_pkg::VALUE_BYTES) ||
               (in_data.op_mode > ubei_pkg::MODE_LIMIT);
    dec_offv = AW'(dec_off);
    dec_lenv = (dec_lenf == 6'd0) ? AW'(ubei_pkg::VALUE_BYTES) : AW'(dec_lenf);
    if ((dec_lenv + dec_offv) > AW'(WINDOW_BYTES)) begin
      dec_len = AW'(WINDOW_BYTES) - dec_offv;
    end else begin
      dec_len = dec_lenv;
    end
    if (((in_data.op_mode & ubei_pkg::MODE_LEFT) != 20'd0) &&
        (dec_len < AW'(ubei_pkg::VALUE_BYTES))) begin
      dec_base = '0;
    end else begin
      dec_base = AW'(ubei_pkg::VALUE_BYTES) - dec_len;
    end
  end

  // Shared lane unit: eight byte lanes build result word k_r
  logic [63:0]   lane_word;
  logic [AW-1:0] pos, rel, src;
  logic          lane_last;

  always_comb begin
    lane_word = '0;
    pos = '0;
    rel = '0;
    src = '0;
    for (int j = 0; j < 8; j++) begin
      pos = AW'({k_r, 3'(j)});
      if (!wr_r) begin
        // extract: value byte pos comes from the window
        rel = pos - base_r;
        src = little_r ? (offs_r + len_r - AW'(1) - rel) : (offs_r + rel);
        if ((pos >= base_r) && (pos < (base_r + len_r))) begin
          lane_word[63-8*j -: 8] = win_r[BW'(src)];
        end
      end else begin
        // insert: window byte pos takes a value byte when inside the span
        rel = pos - offs_r;
        src = little_r ? (base_r + len_r - AW'(1) - rel) : (base_r + rel);
        if ((pos >= offs_r) && (pos < (offs_r + len_r))) begin
          lane_word[63-8*j -: 8] = val_r[5'(src)];
        end else begin
          lane_word[63-8*j -: 8] = win_r[BW'(pos)];
        end
      end
    end
    if (err_r) begin
      lane_last = 1'b1;
    end else if (wr_r) begin
      lane_last = (k_r == 3'(NOUT - 1));
    end else begin
      lane_last = (k_r == 3'(ubei_pkg::VALUE_WORDS - 1));
    end
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_data.kind == ubei_pkg::KIND_EXEC)) begin
          state_nxt = ST_RUN;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = err_r ? ubei_pkg::STATUS_ERR : ubei_pkg::STATUS_OK;
          out_nxt.out_word  = err_r ? 64'd0 : lane_word;
          out_nxt.out_index = err_r ? 3'd0 : k_r;
          out_nxt.last      = lane_last;
          k_nxt             = k_r + 3'd1;
          if (lane_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: result word and latched operation
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && in_ready && (in_data.kind == ubei_pkg::KIND_EXEC)) begin
      offs_r   <= dec_offv;
      len_r    <= dec_len;
      base_r   <= dec_base;
      little_r <= (in_data.op_mode & ubei_pkg::MODE_LITTLE) != 20'd0;
      wr_r     <= in_data.is_write;
      err_r    <= dec_err;
    end
  end

  // Store loads, out-of-range slots are dropped
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if ((in_data.kind == ubei_pkg::KIND_LOAD_WIN) && (32'(in_data.word_index) < WW)) begin
        for (int b = 0; b < 8; b++) begin
          win_r[BW'({in_data.word_index, 3'(b)})] <= in_data.data_word[63-8*b -: 8];
        end
      end
      if ((in_data.kind == ubei_pkg::KIND_LOAD_VAL) &&
          (32'(in_data.word_index) < ubei_pkg::VALUE_WORDS)) begin
        for (int b = 0; b < 8; b++) begin
          val_r[{in_data.word_index[1:0], 3'(b)}] <= in_data.data_word[63-8*b -: 8];
        end
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Error results are single, zero and final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ubei_pkg::STATUS_ERR)) |->
      (out_r.last && (out_r.out_word == 64'd0) && (out_r.out_index == 3'd0)))
    else $error("error result not a single zero word");

  // An execute transfer starts the sequencer
  a_exec_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.kind == ubei_pkg::KIND_EXEC)) |=> (state_r == ST_RUN))
    else $error("execute did not start sequencer");

  // A non-final word is followed at once by the next word
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_r.last) |=> out_valid_r)
    else $error("gap inside result burst");

  // Result index follows the word counter
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_r.last) |=> (out_r.out_index == $past(out_r.out_index) + 3'd1))
    else $error("result index out of sequence");

endmodule

`default_nettype wire

>>> sim/unaligned_byte_extract_insert_tb.sv
// Self-checking testbench for the unaligned byte extract/insert block.
// Directed rows, then random loads and executes, checked against a local aligner model.
// Depends on ubei_pkg and the unaligned_byte_extract_insert RTL.
`default_nettype none

module unaligned_byte_extract_insert_tb;

  localparam int WIN_BYTES    = ubei_pkg::WINDOW_BYTES_DEF;
  localparam int WIN_WORDS    = WIN_BYTES / 8;
  localparam int OUT_WORDS    = (WIN_WORDS > 8) ? 8 : WIN_WORDS;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 360;

  // Kind code the block does not use; such items must be dropped silently
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Single error word for any out-of-range mode
  localparam ubei_pkg::out_t ERR_WORD = '{ubei_pkg::STATUS_ERR, 64'd0, 3'd0, 1'b1};

  typedef struct {
    ubei_pkg::in_t  item;
    bit             typed;
    ubei_pkg::out_t want;
  } stim_row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  ubei_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  ubei_pkg::out_t out_data;

  // Aligner model state and the words it still owes
  logic [63:0]    win_words [WIN_WORDS];
  logic [63:0]    val_words [ubei_pkg::VALUE_WORDS];
  ubei_pkg::out_t pending_words [$];

  // Driver-to-monitor side info for rows with a hand-written result
  bit             row_typed;
  ubei_pkg::out_t typed_want;

  bit in_burst;
  bit out_burst;
  int out_stall;
  int idle_cycles;
  int mismatches;

  unaligned_byte_extract_insert #(
    .WINDOW_BYTES(WIN_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build a mode word from its fields
  function automatic logic [19:0] mode_word(int offs, int lenf, bit left, bit little);
    logic [19:0] m;
    m = '0;
    m[6:0] = offs[6:0];
    m[12:7] = lenf[5:0];
    if (left) m = m | ubei_pkg::MODE_LEFT;
    if (little) m = m | ubei_pkg::MODE_LITTLE;
    return m;
  endfunction

  // Aligner model: updates the stores on loads, queues result words on executes
  function automatic void apply_item(ubei_pkg::in_t item);
    logic [7:0]     wb [WIN_BYTES];
    logic [7:0]     vb [ubei_pkg::VALUE_BYTES];
    logic [7:0]     ob [128];
    logic [63:0]    w;
    int             offs, lenf, len, base, src, nwords, i, k, b;
    bit             left, little;
    ubei_pkg::out_t res;
    case (item.kind)
      ubei_pkg::KIND_LOAD_WIN: begin
        if (item.word_index < WIN_WORDS) win_words[item.word_index] = item.data_word;
      end
      ubei_pkg::KIND_LOAD_VAL: begin
        if (item.word_index < ubei_pkg::VALUE_WORDS)
          val_words[item.word_index[1:0]] = item.data_word;
      end
      ubei_pkg::KIND_EXEC: begin
        offs = int'(item.op_mode[6:0]);
        lenf = int'(item.op_mode[12:7]);
        left = (item.op_mode & ubei_pkg::MODE_LEFT) != '0;
        little = (item.op_mode & ubei_pkg::MODE_LITTLE) != '0;
        if (offs > WIN_BYTES || lenf > ubei_pkg::VALUE_BYTES ||
            item.op_mode > ubei_pkg::MODE_LIMIT) begin
          pending_words = {pending_words, ERR_WORD};
        end else begin
          len = (lenf == 0) ? ubei_pkg::VALUE_BYTES : lenf;
          if (len + offs > WIN_BYTES) len = WIN_BYTES - offs;
          base = (left && len < ubei_pkg::VALUE_BYTES) ? 0 : ubei_pkg::VALUE_BYTES - len;
          for (i = 0; i < WIN_BYTES; i++) wb[i] = win_words[i / 8][8 * (7 - i % 8) +: 8];
          for (i = 0; i < ubei_pkg::VALUE_BYTES; i++)
            vb[i] = val_words[i / 8][8 * (7 - i % 8) +: 8];
          if (!item.is_write) begin
            // Extract: right-aligned by default, top-aligned when left align is set
            for (i = 0; i < ubei_pkg::VALUE_BYTES; i++) ob[i] = 8'h00;
            for (k = 0; k < len; k++) begin
              src = little ? offs + len - 1 - k : offs + k;
              ob[base + k] = wb[src];
            end
            nwords = ubei_pkg::VALUE_WORDS;
          end else begin
            // Insert: splice value bytes into a copy of the window
            for (k = 0; k < len; k++) begin
              src = little ? base + len - 1 - k : base + k;
              wb[offs + k] = vb[src];
            end
            for (i = 0; i < WIN_BYTES; i++) ob[i] = wb[i];
            nwords = OUT_WORDS;
          end
          for (i = 0; i < nwords; i++) begin
            w = '0;
            for (b = 0; b < 8; b++) w = {w[55:0], ob[i * 8 + b]};
            res.status = ubei_pkg::STATUS_OK;
            res.out_word = w;
            res.out_index = 3'(i);
            res.last = (i == nwords - 1);
            pending_words = {pending_words, res};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // Monitor: predicts on input transfers, checks output transfers, watchdog
  always @(posedge clk) begin
    ubei_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (row_typed) pending_words = {pending_words, typed_want};
        else apply_item(in_data);
      end
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 6);
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_words.pop_front();
          if (out_data.status !== want.status)
            flag_field("status", 64'(want.status), 64'(out_data.status));
          if (out_data.out_word !== want.out_word)
            flag_field("out_word", want.out_word, out_data.out_word);
          if (out_data.out_index !== want.out_index)
            flag_field("out_index", 64'(want.out_index), 64'(out_data.out_index));
          if (out_data.last !== want.last)
            flag_field("last", 64'(want.last), 64'(out_data.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: stalls for the drawn number of cycles before each result
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Sender: random gap, then hold valid until the transfer
  task automatic send(ubei_pkg::in_t item, bit typed, ubei_pkg::out_t want);
    int gap;
    if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = item;
    row_typed = typed;
    typed_want = want;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic stim_row_t row(logic [1:0] kind, int idx, logic [63:0] data,
                                    logic [19:0] mode, bit wr, bit typed,
                                    ubei_pkg::out_t want);
    stim_row_t r;
    r.item.kind = kind;
    r.item.word_index = 3'(idx);
    r.item.data_word = data;
    r.item.op_mode = mode;
    r.item.is_write = wr;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic ubei_pkg::in_t random_item();
    ubei_pkg::in_t item;
    int            pick;
    item.kind = ubei_pkg::KIND_EXEC;
    item.word_index = 3'($urandom_range(0, 7));
    item.data_word = {$urandom, $urandom};
    item.op_mode = 20'($urandom_range(0, 20'hFFFFF));
    item.is_write = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      item.kind = ubei_pkg::KIND_LOAD_WIN;
    end else if (pick < 45) begin
      item.kind = ubei_pkg::KIND_LOAD_VAL;
    end else if (pick < 92) begin
      // Legal mode, offsets weighted toward the top of the window
      item.op_mode = mode_word(($urandom_range(0, 3) == 0) ? $urandom_range(56, 64)
                                                           : $urandom_range(0, 64),
                               $urandom_range(0, 32), 1'($urandom), 1'($urandom));
      item.op_mode[18:15] = 4'($urandom);
    end else if (pick < 97) begin
      // Out-of-range mode: one violation forced over random bits
      case ($urandom_range(0, 2))
        0: item.op_mode[6:0] = 7'($urandom_range(WIN_BYTES + 1, 127));
        1: item.op_mode[12:7] = 6'($urandom_range(ubei_pkg::VALUE_BYTES + 1, 63));
        default: item.op_mode[19] = 1'b1;
      endcase
    end else begin
      item.kind = KIND_UNUSED;
    end
    return item;
  endfunction

  initial begin
    stim_row_t     directed_rows [$];
    ubei_pkg::in_t item;
    int            i, counted;
    bit            drained;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    row_typed = 1'b0;
    typed_want = '0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    out_stall = 0;
    idle_cycles = 0;
    mismatches = 0;

    // Fill both stores first so no execute touches an unloaded word
    for (i = 0; i < WIN_WORDS; i++)
      directed_rows = {directed_rows,
                       row(ubei_pkg::KIND_LOAD_WIN, i,
                           64'h0001020304050607 + 64'(i) * 64'h0808080808080808,
                           '0, 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_LOAD_VAL, 0, 64'hFFFF_FFFF_FFFF_FFFF,
                                        '1, 1'b1, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_LOAD_VAL, 1, 64'h0,
                                        '0, 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_LOAD_VAL, 2, 64'h0123_4567_89AB_CDEF,
                                        '0, 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_LOAD_VAL, 3, 64'hFEDC_BA98_7654_3210,
                                        '0, 1'b0, 1'b0, '0)};
    // Extracts: full length, zero length at the end, clipped, reversed, left aligned
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(0, 0, 1'b0, 1'b0), 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(64, 0, 1'b0, 1'b0), 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(60, 8, 1'b1, 1'b1), 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(5, 3, 1'b1, 1'b0), 1'b0, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(33, 32, 1'b0, 1'b1), 1'b0, 1'b0, '0)};
    // Inserts: full length, no-op at the end, clipped, single byte
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(0, 0, 1'b0, 1'b0), 1'b1, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(64, 32, 1'b1, 1'b1), 1'b1, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(61, 32, 1'b1, 1'b1), 1'b1, 1'b0, '0)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(7, 1, 1'b1, 1'b0), 1'b1, 1'b0, '0)};
    // Spare high mode bits below the limit are legal
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(10, 20, 1'b0, 1'b0) | 20'h78000, 1'b0, 1'b0, '0)};
    // Out-of-range modes give the single error word
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(65, 4, 1'b0, 1'b0), 1'b0, 1'b1, ERR_WORD)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     mode_word(0, 33, 1'b0, 1'b0), 1'b1, 1'b1, ERR_WORD)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     20'h80000, 1'b0, 1'b1, ERR_WORD)};
    directed_rows = {directed_rows, row(ubei_pkg::KIND_EXEC, 0, '0,
                     20'hFFFFF, 1'b1, 1'b1, ERR_WORD)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[n])
      send(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);

    // Random part; ignored items do not advance the count
    counted = 0;
    drained = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      item = random_item();
      if (!(item.kind == KIND_UNUSED ||
            (item.kind == ubei_pkg::KIND_LOAD_VAL &&
             item.word_index >= ubei_pkg::VALUE_WORDS)))
        counted++;
      if (!drained && counted >= RANDOM_ITEMS / 2) begin
        // Hold off the sender until every owed word has come out
        drained = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
      send(item, 1'b0, '0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
